// ===== rtl/core/smf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int MAX_RADIUS   = 16;
    localparam int STORE_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int RADIUS_W     = 5;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int DATA_W       = 32;

    localparam logic [RADIUS_W-1:0] RESET_RADIUS = RADIUS_W'(12);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     series_start;
        logic                     series_end;
    } smf_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] median_value;
        logic                     is_last;
    } smf_out_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } smf_result_t;

    // clamp radius to 1..MAX_RADIUS and return the window length 2r+1
    function automatic logic [CNT_W-1:0] window_len(input logic [RADIUS_W-1:0] radius);
        logic [CNT_W-1:0] r;
        r = CNT_W'(radius);
        if (r < CNT_W'(1)) begin
            r = CNT_W'(1);
        end
        if (r > CNT_W'(MAX_RADIUS)) begin
            r = CNT_W'(MAX_RADIUS);
        end
        return CNT_W'({r, 1'b1});
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/smf_window_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_window_ram
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smf_window_ram (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [smf_pkg::IDX_W-1:0]        wr_addr,
    input  wire logic signed [smf_pkg::DATA_W-1:0] wr_data,
    input  wire logic [smf_pkg::IDX_W-1:0]        rd_addr,
    output logic signed [smf_pkg::DATA_W-1:0]     rd_data
);
    import smf_pkg::*;

    logic signed [DATA_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/smf_rank_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_rank_seq
// Stores samples and finds the window median by ranking one candidate at a
// time against the window with a single comparator.
// ----------------------------------------------------------------------------
module smf_rank_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire smf_pkg::smf_in_t                in_data,
    input  wire logic [smf_pkg::RADIUS_W-1:0]    radius,
    input  wire logic                            out_free,
    output smf_pkg::smf_result_t                 result
);
    import smf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAND  = 3'd1;
    localparam logic [2:0] S_LOADC = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [IDX_W-1:0]         wslot_reg, wslot_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [IDX_W-1:0]         base_reg, base_next;
    logic [CNT_W-1:0]         cand_idx_reg, cand_idx_next;
    logic [CNT_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]         below_reg, below_next;
    logic [CNT_W-1:0]         same_reg, same_next;
    logic signed [DATA_W-1:0] cand_reg, cand_next;
    logic                     last_reg, last_next;

    logic                     accept;
    logic [IDX_W-1:0]         wslot_inc;
    logic [CNT_W-1:0]         fill_base;
    logic [CNT_W-1:0]         fill_new;
    logic [CNT_W-1:0]         len_now;
    logic [IDX_W:0]           base_calc;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]         mid;
    logic [CNT_W:0]           upper;
    logic                     found;

    // slot of window offset k, counted from the oldest sample
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] k);
        logic [IDX_W:0] sum;
        sum = (IDX_W+1)'(base) + (IDX_W+1)'(k);
        if (sum >= (IDX_W+1)'(STORE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(STORE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    smf_window_ram u_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wslot_reg),
        .wr_data (in_data.sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign wslot_inc = (wslot_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : wslot_reg + 1'b1;
    assign fill_base = in_data.series_start ? '0 : fill_reg;
    assign fill_new  = (fill_base < CNT_W'(STORE_DEPTH)) ? fill_base + 1'b1 : fill_base;
    assign len_now   = window_len(radius);
    assign base_calc = ((IDX_W+1)'(wslot_inc) >= (IDX_W+1)'(len_now))
                     ? (IDX_W+1)'(wslot_inc) - (IDX_W+1)'(len_now)
                     : (IDX_W+1)'(wslot_inc) + (IDX_W+1)'(STORE_DEPTH) - (IDX_W+1)'(len_now);

    assign mid   = len_reg >> 1;
    assign upper = (CNT_W+1)'(below_reg) + (CNT_W+1)'(same_reg);
    assign found = (below_reg <= mid) && ((CNT_W+1)'(mid) < upper);

    always_comb begin
        unique case (state_reg)
            S_CAND:  rd_addr = slot_of(base_reg, cand_idx_reg);
            S_LOADC: rd_addr = slot_of(base_reg, '0);
            S_SCAN:  rd_addr = slot_of(base_reg, scan_idx_reg);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        wslot_next    = wslot_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        base_next     = base_reg;
        cand_idx_next = cand_idx_reg;
        scan_idx_next = scan_idx_reg;
        below_next    = below_reg;
        same_next     = same_reg;
        cand_next     = cand_reg;
        last_next     = last_reg;
        result.valid  = 1'b0;
        result.value  = cand_reg;
        result.last   = last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    wslot_next    = wslot_inc;
                    fill_next     = fill_new;
                    len_next      = len_now;
                    base_next     = base_calc[IDX_W-1:0];
                    last_next     = in_data.series_end;
                    cand_idx_next = '0;
                    if (fill_new >= len_now) begin
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND: begin
                state_next = S_LOADC;
            end
            S_LOADC: begin
                cand_next     = rd_data;
                below_next    = '0;
                same_next     = '0;
                scan_idx_next = CNT_W'(1);
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                // read data is entry scan_idx-1
                if (rd_data < cand_reg) begin
                    below_next = below_reg + 1'b1;
                end else if (rd_data == cand_reg) begin
                    same_next = same_reg + 1'b1;
                end
                if (scan_idx_reg == len_reg) begin
                    state_next = S_CHECK;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_CHECK: begin
                if (found) begin
                    if (out_free) begin
                        result.valid = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = S_CAND;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wslot_reg <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wslot_reg <= wslot_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        base_reg     <= base_next;
        cand_idx_reg <= cand_idx_next;
        scan_idx_reg <= scan_idx_next;
        below_reg    <= below_next;
        same_reg     <= same_next;
        cand_reg     <= cand_next;
        last_reg     <= last_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sliding_median_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_median_filter_unit
// Running median over the last 2R+1 samples of a series, signed Q16.16.
// ----------------------------------------------------------------------------
// channel   dir  handshake                payload
// s_        in   s_valid / s_ready        smf_in_t  {sample, series_start, series_end}
// m_        out  m_valid / m_ready        smf_out_t {median_value, is_last}
// cfg_      in   cfg_wr_en (no wait)      cfg_wr_data = window_radius
//
// an item that gives no result leaves the input open; one that gives a result closes it
// while c candidates are ranked against all L = 2R+1 window entries (c = 1..L), each
// through the single comparator and the one read port of the sample store.
// reset clears control, fill and slot and loads radius 12; store contents are not cleared.
// a result waits in the output register; the next item is taken meanwhile, and a later
// result holds the ranking unit until the register is free.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire smf_pkg::smf_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output smf_pkg::smf_out_t                   m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [smf_pkg::RADIUS_W-1:0]   cfg_wr_data
);
    import smf_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic                m_valid_reg;
    smf_out_t            m_data_reg;
    logic                out_free;
    smf_result_t         result;

    assign out_free = !m_valid_reg || m_ready;

    smf_rank_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .radius   (radius_reg),
        .out_free (out_free),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RESET_RADIUS;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            if (result.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_data_reg.median_value <= result.value;
            m_data_reg.is_last      <= result.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/smf_port_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_port_checker
// Port-level checks for the sliding median filter, bound to the top level.
// ----------------------------------------------------------------------------
module smf_port_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire smf_pkg::smf_out_t            m_data
);
    import smf_pkg::*;

    // reset leaves no beat pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not idle after reset");

    // a new result only comes out of a ranking pass, while input is closed
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while input was open");

    // no new result appears in the cycle after a beat is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result one cycle after input beat");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

endmodule

bind sliding_median_filter_unit smf_port_checker u_port_checker (.*);
`default_nettype wire

// ===== sim/sliding_median_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_filter_unit_tb
// Self-checking bench for the running median filter. A short stimulus table
// covers sample extremes, series start and end marks, radius clamping and a
// radius change inside a series. Then come random series at several radii.
// Every result beat is checked against a table value or an in-bench window
// model, mostly under random idling and backpressure on both channels.
// ----------------------------------------------------------------------------
module sliding_median_filter_unit_tb;
    import smf_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DIR_ROWS    = 25;
    localparam int HOLD_CYCLES = 600;

    typedef enum logic [0:0] {ROW_CFG, ROW_BEAT} row_kind_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_VALUE} exp_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [RADIUS_W-1:0]      cfg_val;
        logic signed [DATA_W-1:0] sample;
        logic                     start;
        logic                     fin;
        exp_kind_t                ek;
        logic signed [DATA_W-1:0] exp_val;
        logic                     exp_last;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    smf_in_t             s_data;
    logic                m_valid;
    logic                m_ready;
    smf_out_t            m_data;
    logic                cfg_wr_en;
    logic [RADIUS_W-1:0] cfg_wr_data;

    // window model state
    logic signed [DATA_W-1:0] win_hist [STORE_DEPTH];
    int                       win_fill;
    int                       win_slot;
    logic [RADIUS_W-1:0]      radius_now;

    smf_out_t  pending_medians [$];
    smf_out_t  want;
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct  = 0;
    int        rx_idle_pct  = 0;
    int        hold_req     = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    dir_row_t  dir_tab [DIR_ROWS];

    always #4 aclk = ~aclk;

    sliding_median_filter_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic int window_span(input logic [RADIUS_W-1:0] rad);
        int r;
        r = rad;
        if (r < 1) r = 1;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        return 2 * r + 1;
    endfunction

    // store one sample, return 1 with the median when the window is full
    function automatic bit advance_window(input smf_in_t d, output smf_out_t r);
        logic signed [DATA_W-1:0] win [STORE_DEPTH];
        logic signed [DATA_W-1:0] key;
        int span, slot, i, j;
        span = window_span(radius_now);
        r = '0;
        if (d.series_start) win_fill = 0;
        win_hist[win_slot] = d.sample;
        win_slot = (win_slot + 1) % STORE_DEPTH;
        if (win_fill < STORE_DEPTH) win_fill++;
        if (win_fill < span) return 1'b0;
        slot = win_slot;
        // insertion sort of the newest span samples
        for (i = 0; i < span; i++) begin
            slot = (slot == 0) ? STORE_DEPTH - 1 : slot - 1;
            key = win_hist[slot];
            j = i;
            while (j > 0 && win[j-1] > key) begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        r.median_value = win[span / 2];
        r.is_last      = d.series_end;
        return 1'b1;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int unsigned sel;
        logic signed [DATA_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom;
        end else if (sel < 70) begin
            // narrow range so ties are common
            v = $signed($urandom_range(4)) - 2;
        end else if (sel < 85) begin
            case ($urandom_range(3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7fff_ffff;
                2: v = 32'sd0;
                default: v = -32'sd1;
            endcase
        end else begin
            v = 32'sh00a0_0000 + $signed($urandom_range(255)) - 128;
        end
        return v;
    endfunction

    task automatic push_beat(input smf_in_t d, input exp_kind_t ek,
                             input logic signed [DATA_W-1:0] ev, input logic el);
        smf_out_t r;
        bit       has;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        has = advance_window(d, r);
        if (ek == EXP_VALUE) begin
            r.median_value = ev;
            r.is_last      = el;
            pending_medians.push_back(r);
        end else if (ek == EXP_PRED && has) begin
            pending_medians.push_back(r);
        end
        @(negedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] v);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        // a sample with no result may still be in flight
        repeat (16) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        radius_now = v;
    endtask

    // result side: random idling plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0d last %0b",
                         $time, m_data.median_value, m_data.is_last);
                mismatch_cnt++;
            end else begin
                want = pending_medians.pop_front();
                if (m_data.median_value !== want.median_value) begin
                    $display("%0t: median mismatch, expected %0d, actual %0d",
                             $time, want.median_value, m_data.median_value);
                    mismatch_cnt++;
                end
                if (m_data.is_last !== want.is_last) begin
                    $display("%0t: is_last mismatch, expected %0b, actual %0b",
                             $time, want.is_last, m_data.is_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        smf_in_t             d;
        logic [RADIUS_W-1:0] rad;
        int                  cnt, ph, n, k, span, roll, rnd_idx, series_left;
        bit                  opening, with_start;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        win_fill    = 0;
        win_slot    = 0;
        radius_now  = RESET_RADIUS;
        rnd_idx     = 0;
        series_left = 0;
        with_start  = 1'b1;

        //               kind      cfg    sample          st    end   check      value         last
        dir_tab[0]  = '{ROW_BEAT, 5'd0,  32'sh0001_0000, 1'b1, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[1]  = '{ROW_BEAT, 5'd0,  32'shfffe_0000, 1'b0, 1'b1, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[2]  = '{ROW_CFG,  5'd0,  32'sd0,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[3]  = '{ROW_BEAT, 5'd0,  32'sh8000_0000, 1'b1, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[4]  = '{ROW_BEAT, 5'd0,  32'sh7fff_ffff, 1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[5]  = '{ROW_BEAT, 5'd0,  32'sd0,         1'b0, 1'b0, EXP_VALUE, 32'sd0,        1'b0};
        dir_tab[6]  = '{ROW_BEAT, 5'd0,  32'sh7fff_ffff, 1'b0, 1'b1, EXP_VALUE, 32'sh7fff_ffff, 1'b1};
        dir_tab[7]  = '{ROW_BEAT, 5'd0,  32'shffff_ffff, 1'b0, 1'b0, EXP_VALUE, 32'sd0,        1'b0};
        dir_tab[8]  = '{ROW_BEAT, 5'd0,  32'sd5,         1'b1, 1'b1, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[9]  = '{ROW_BEAT, 5'd0,  32'sd4,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[10] = '{ROW_BEAT, 5'd0,  32'sd3,         1'b0, 1'b0, EXP_VALUE, 32'sd4,        1'b0};
        dir_tab[11] = '{ROW_CFG,  5'd2,  32'sd0,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[12] = '{ROW_BEAT, 5'd0,  32'sd2,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[13] = '{ROW_BEAT, 5'd0,  32'sd1,         1'b0, 1'b0, EXP_VALUE, 32'sd3,        1'b0};
        dir_tab[14] = '{ROW_CFG,  5'd31, 32'sd0,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[15] = '{ROW_BEAT, 5'd0,  32'sh8000_0000, 1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[16] = '{ROW_CFG,  5'd1,  32'sd0,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[17] = '{ROW_BEAT, 5'd0,  32'sh8000_0000, 1'b0, 1'b1, EXP_VALUE, 32'sh8000_0000, 1'b1};
        dir_tab[18] = '{ROW_BEAT, 5'd0,  32'sd7,         1'b1, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[19] = '{ROW_BEAT, 5'd0,  32'sd7,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[20] = '{ROW_BEAT, 5'd0,  32'sd7,         1'b0, 1'b0, EXP_VALUE, 32'sd7,        1'b0};
        dir_tab[21] = '{ROW_BEAT, 5'd0,  -32'sd5,        1'b0, 1'b0, EXP_PRED,  32'sd0,        1'b0};
        dir_tab[22] = '{ROW_BEAT, 5'd0,  32'sh7fff_ffff, 1'b0, 1'b0, EXP_PRED,  32'sd0,        1'b0};
        dir_tab[23] = '{ROW_CFG,  5'd12, 32'sd0,         1'b0, 1'b0, EXP_NONE,  32'sd0,        1'b0};
        dir_tab[24] = '{ROW_BEAT, 5'd0,  32'sd0,         1'b1, 1'b0, EXP_NONE,  32'sd0,        1'b0};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 27;
        rx_idle_pct = 85;
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                write_radius(dir_tab[k].cfg_val);
            end else begin
                d.sample       = dir_tab[k].sample;
                d.series_start = dir_tab[k].start;
                d.series_end   = dir_tab[k].fin;
                push_beat(d, dir_tab[k].ek, dir_tab[k].exp_val, dir_tab[k].exp_last);
            end
        end

        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin rad = 5'd12; cnt = 60;  end
                1: begin rad = 5'd1;  cnt = 250; end
                2: begin rad = 5'd0;  cnt = 120; end
                3: begin rad = 5'd3;  cnt = 200; end
                4: begin rad = 5'd31; cnt = 50;  end
                5: begin rad = 5'd2;  cnt = 200; end
                6: begin rad = 5'd5;  cnt = 150; end
                7: begin rad = 5'd16; cnt = 50;  end
                8: begin rad = 5'd7;  cnt = 100; end
                default: begin rad = 5'd1; cnt = 150; end
            endcase
            // the open series carries over, so the radius can change mid-series
            write_radius(rad);
            span = window_span(rad);
            for (n = 0; n < cnt; n++) begin
                if (rnd_idx < 450) begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 85;
                end else if (rnd_idx < 900) begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 27;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (rnd_idx == 300 || rnd_idx == 1000) hold_req++;
                opening = (series_left == 0);
                if (opening) begin
                    roll = $urandom_range(99);
                    with_start = 1'b1;
                    if (roll < 85) begin
                        series_left = $urandom_range(span, span + ((span <= 11) ? 24 : 8));
                    end else if (roll < 95) begin
                        series_left = $urandom_range(span, 1);
                    end else begin
                        // keep going without a start mark
                        series_left = $urandom_range(10, 1);
                        with_start  = 1'b0;
                    end
                end
                series_left--;
                d.sample       = pick_sample();
                d.series_start = opening ? with_start : ($urandom_range(199) == 0);
                d.series_end   = (series_left == 0) ? 1'b1 : ($urandom_range(99) == 0);
                push_beat(d, EXP_PRED, 32'sd0, 1'b0);
                rnd_idx++;
            end
        end

        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
